// ----- design/depth_to_normal_map_macros.svh -----
// ----------------------------------------------------------------------------
// Depth-to-normal-map assertion macros
// Shared concurrent assertion forms for the normal-map block.
// ----------------------------------------------------------------------------
`ifndef DEPTH_TO_NORMAL_MAP_MACROS_SVH
`define DEPTH_TO_NORMAL_MAP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DTN_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DTN_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dtn_pkg.sv -----
// ----------------------------------------------------------------------------
// Depth-to-normal-map package
// Widths, register codes, ring geometry and shared types.
// ----------------------------------------------------------------------------
package dtn_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int DEPTH_BITS = 24;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int MIN_DIM    = 3;

    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int SCALE_W    = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_SCALE   = 2'd2;

    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 12'd1024;
    localparam logic [SCALE_W-1:0]  RST_STEP_SCALE   = 24'd32768;

    localparam int RING_N   = 8;
    localparam int RING_IW  = $clog2(RING_N);
    localparam int DIFF_W   = DEPTH_BITS + 1;
    localparam int XY_SHIFT = 8;
    localparam int MAG_W    = 34;
    localparam int PRE_W    = 24;
    localparam int SQ_W     = 2 * PRE_W + 2;
    localparam int ROOT_W   = 25;
    localparam int RES_W    = SQ_W + 1;
    localparam int DIV_D_W  = ROOT_W + 1;
    localparam int QUO_W    = 31;
    localparam int ITER_W   = $clog2(QUO_W + 1);
    localparam int SUM_W    = 35;
    localparam int CHAN_W   = 8;
    localparam int NUM_W    = DIV_D_W + CHAN_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Window index of a ring offset: 0 is -1, 1 is 0, 2 is +1.
    localparam logic [1:0] RING_NEG  = 2'd0;
    localparam logic [1:0] RING_ZERO = 2'd1;
    localparam logic [1:0] RING_POS  = 2'd2;

    typedef struct packed {
        logic [RING_N-1:0][DIFF_W-1:0] diff;
        logic                          masked;
        logic                          last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic               start;
        logic [DIV_D_W-1:0] hi;
        logic [QUO_W-1:0]   lo;
        logic [ITER_W-1:0]  iters;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_LOAD     = 8'b0000_0010,
        ST_NORM     = 8'b0000_0100,
        ST_SQ       = 8'b0000_1000,
        ST_ROOT     = 8'b0001_0000,
        ST_DIV_GO   = 8'b0010_0000,
        ST_DIV_WAIT = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } back_state_t;

    function automatic logic [1:0] ring_row_idx(input logic [RING_IW-1:0] t);
        case (t)
            3'd0, 3'd1, 3'd2: return RING_NEG;
            3'd4, 3'd5, 3'd6: return RING_POS;
            default:          return RING_ZERO;
        endcase
    endfunction

    function automatic logic [1:0] ring_col_idx(input logic [RING_IW-1:0] t);
        case (t)
            3'd0, 3'd6, 3'd7: return RING_NEG;
            3'd2, 3'd3, 3'd4: return RING_POS;
            default:          return RING_ZERO;
        endcase
    endfunction

    // Offset times depth difference, offset in {-1, 0, +1}.
    function automatic logic signed [DIFF_W:0] ring_term(input logic [1:0] idx,
                                                        input logic [DIFF_W-1:0] e);
        logic signed [DIFF_W:0] ex;
        ex = $signed({e[DIFF_W-1], e});
        case (idx)
            RING_NEG: return -ex;
            RING_POS: return ex;
            default:  return '0;
        endcase
    endfunction

endpackage

// ----- design/dtn_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/dtn_front.sv -----
// ----------------------------------------------------------------------------
// Normal-map front end
// Line buffers, 3x3 window and raster counters; emits one job per interior pixel.
// ----------------------------------------------------------------------------
module dtn_front import dtn_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DEPTH_BITS-1:0] s_depth_sample,
    input  logic [WIDTH_W-1:0]    image_width,
    input  logic [HEIGHT_W-1:0]   image_height,
    input  logic                  q_full,
    output logic                  push,
    output job_t                  job
);

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [COL_W-1:0]    col_reg;
    logic [HEIGHT_W-1:0] row_reg;
    logic [WIDTH_W:0]    col_inc;
    logic [HEIGHT_W:0]   row_inc;
    logic                accept;

    logic                  stg_valid_reg;
    logic [DEPTH_BITS-1:0] stg_cur_reg;
    logic [COL_W-1:0]      stg_col_reg;
    logic                  stg_emit_reg;
    logic                  stg_last_reg;
    logic                  stg_fire;

    logic [DEPTH_BITS-1:0] top_rd;
    logic [DEPTH_BITS-1:0] mid_rd;
    logic [DEPTH_BITS-1:0] win_reg [3][3];
    logic [DEPTH_BITS-1:0] win_new [3][3];
    logic [DEPTH_BITS-1:0] hc;

    always_comb begin
        if (image_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else if (image_width < WIDTH_W'(MIN_DIM)) begin
            w_eff = WIDTH_W'(MIN_DIM);
        end else begin
            w_eff = image_width;
        end
        if (image_height < HEIGHT_W'(MIN_DIM)) begin
            h_eff = HEIGHT_W'(MIN_DIM);
        end else begin
            h_eff = image_height;
        end
    end

    assign col_inc  = (WIDTH_W + 1)'(col_reg) + 1'b1;
    assign row_inc  = (HEIGHT_W + 1)'(row_reg) + 1'b1;
    assign stg_fire = stg_valid_reg && (!stg_emit_reg || !q_full);
    assign s_ready  = !stg_valid_reg || stg_fire;
    assign accept   = s_valid && s_ready;

    // counters advance at accept; the stage keeps its own column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            stg_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                stg_valid_reg <= 1'b1;
                stg_cur_reg   <= s_depth_sample;
                stg_col_reg   <= col_reg;
                stg_emit_reg  <= (row_reg >= HEIGHT_W'(2)) && (col_reg >= COL_W'(2));
                stg_last_reg  <= (row_inc == {1'b0, h_eff}) && (col_inc == {1'b0, w_eff});
                if (col_inc >= {1'b0, w_eff}) begin
                    col_reg <= '0;
                    row_reg <= (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[HEIGHT_W-1:0];
                end else begin
                    col_reg <= col_inc[COL_W-1:0];
                end
            end else if (stg_fire) begin
                stg_valid_reg <= 1'b0;
            end
        end
    end

    dtn_ram #(.WIDTH(DEPTH_BITS), .DEPTH(MAX_WIDTH)) u_line_top (
        .aclk  (aclk),
        .we    (stg_fire),
        .waddr (stg_col_reg),
        .wdata (mid_rd),
        .re    (accept),
        .raddr (col_reg),
        .rdata (top_rd)
    );

    dtn_ram #(.WIDTH(DEPTH_BITS), .DEPTH(MAX_WIDTH)) u_line_mid (
        .aclk  (aclk),
        .we    (stg_fire),
        .waddr (stg_col_reg),
        .wdata (stg_cur_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_new[r][0] = win_reg[r][1];
            win_new[r][1] = win_reg[r][2];
        end
        win_new[0][2] = top_rd;
        win_new[1][2] = mid_rd;
        win_new[2][2] = stg_cur_reg;
    end

    always_ff @(posedge aclk) begin
        if (stg_fire) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= win_new[r][c];
                end
            end
        end
    end

    assign hc = win_new[1][1];

    always_comb begin
        for (int t = 0; t < RING_N; t++) begin
            job.diff[t] = DIFF_W'($signed(
                {win_new[ring_row_idx(RING_IW'(t))][ring_col_idx(RING_IW'(t))][DEPTH_BITS-1],
                 win_new[ring_row_idx(RING_IW'(t))][ring_col_idx(RING_IW'(t))]})
                - $signed({hc[DEPTH_BITS-1], hc}));
        end
        job.masked = hc[DEPTH_BITS-1] || (hc == '0);
        job.last   = stg_last_reg;
    end

    assign push = stg_fire && stg_emit_reg;

endmodule

// ----- design/dtn_queue.sv -----
// ----------------------------------------------------------------------------
// Normal-map job queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dtn_queue import dtn_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  job_t      wr_job,
    input  logic      pop,
    output job_t      rd_job,
    output q_status_t status
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_job       = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/dtn_div.sv -----
// ----------------------------------------------------------------------------
// Normal-map divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtn_div import dtn_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] d_reg;
    logic [QUO_W-1:0]   lo_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [ITER_W-1:0]  cnt_reg;
    logic               run_reg;
    logic               done_reg;
    logic [DIV_D_W:0]   trial;
    logic               ge;

    assign trial = {rem_reg, lo_reg[QUO_W-1]};
    assign ge    = (trial >= {1'b0, d_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg <= req.hi;
                lo_reg  <= req.lo;
                d_reg   <= req.divisor;
                quo_reg <= '0;
                cnt_reg <= req.iters;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                rem_reg <= ge ? DIV_D_W'(trial - {1'b0, d_reg}) : trial[DIV_D_W-1:0];
                lo_reg  <= {lo_reg[QUO_W-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- design/dtn_back.sv -----
// ----------------------------------------------------------------------------
// Normal-map back end
// Sequencer over eight triangles: prescale, square-sum, root, divide, sum; then a final renormalize.
// ----------------------------------------------------------------------------
module dtn_back import dtn_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  job_t               job,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic [SCALE_W-1:0] step_scale,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAN_W-1:0]  m_chan_x,
    output logic [CHAN_W-1:0]  m_chan_y,
    output logic [CHAN_W-1:0]  m_chan_z,
    output logic               m_last_of_frame
);

    back_state_t state_reg;

    job_t                job_reg;
    logic                final_reg;
    logic [RING_IW-1:0]  tri_reg;
    logic [1:0]          comp_reg;
    logic [MAG_W-1:0]    mag_reg [3];
    logic [2:0]          neg_reg;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic [1:0]          sq_cnt_reg;
    logic [2*PRE_W-1:0]  prod_reg;
    logic [SQ_W-1:0]     acc_reg;
    logic [SQ_W-1:0]     root_n_reg;
    logic [RES_W-1:0]    root_res_reg;
    logic [SQ_W-1:0]     root_bit_reg;
    logic [CHAN_W-1:0]   chan_reg [3];

    logic               m_valid_reg;
    logic [CHAN_W-1:0]  m_x_reg;
    logic [CHAN_W-1:0]  m_y_reg;
    logic [CHAN_W-1:0]  m_z_reg;
    logic               m_last_reg;

    localparam logic [SQ_W-1:0] ROOT_BIT0 = SQ_W'(1) << (2 * (ROOT_W - 1));

    logic [RING_IW-1:0]         tri_nxt;
    logic signed [DIFF_W:0]     tx_a, tx_b, ty_a, ty_b;
    logic signed [DIFF_W+1:0]   dx, dy;
    logic [DIFF_W+1:0]          absdx, absdy;
    logic [MAG_W-1:0]           xmag, ymag, zmag;
    logic [SCALE_W-1:0]         s_eff;
    logic [MAG_W-1:0]           sum_mag [3];
    logic                       over;
    logic [PRE_W-1:0]           sq_op;
    logic [RES_W-1:0]           root_trial;
    logic                       root_ge;
    logic [ROOT_W-1:0]          root_r;
    logic [PRE_W-1:0]           m24;
    logic [DIV_D_W-1:0]         a_val;
    logic [NUM_W-1:0]           num;
    logic [SUM_W-1:0]           q_ext;
    div_req_t                   div_req;
    logic                       div_done;
    logic [QUO_W-1:0]           div_quo;
    logic                       out_load;

    // triangle vector from the centre and two consecutive ring neighbours
    assign tri_nxt = tri_reg + 1'b1;
    assign tx_a = ring_term(ring_col_idx(tri_nxt), job_reg.diff[tri_reg]);
    assign tx_b = ring_term(ring_col_idx(tri_reg), job_reg.diff[tri_nxt]);
    assign ty_a = ring_term(ring_row_idx(tri_reg), job_reg.diff[tri_nxt]);
    assign ty_b = ring_term(ring_row_idx(tri_nxt), job_reg.diff[tri_reg]);
    assign dx   = $signed({tx_a[DIFF_W], tx_a}) - $signed({tx_b[DIFF_W], tx_b});
    assign dy   = $signed({ty_a[DIFF_W], ty_a}) - $signed({ty_b[DIFF_W], ty_b});
    assign absdx = dx[DIFF_W+1] ? -dx : dx;
    assign absdy = dy[DIFF_W+1] ? -dy : dy;
    assign xmag  = MAG_W'({absdx, XY_SHIFT'(0)});
    assign ymag  = MAG_W'({absdy, XY_SHIFT'(0)});
    assign s_eff = (step_scale == '0) ? SCALE_W'(1) : step_scale;
    assign zmag  = MAG_W'(s_eff);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum_mag[k] = sum_reg[k][SUM_W-1] ? MAG_W'(-sum_reg[k]) : MAG_W'(sum_reg[k]);
        end
    end

    assign over = |(mag_reg[0][MAG_W-1:PRE_W] | mag_reg[1][MAG_W-1:PRE_W]
                    | mag_reg[2][MAG_W-1:PRE_W]);

    always_comb begin
        case (sq_cnt_reg)
            2'd0:    sq_op = mag_reg[0][PRE_W-1:0];
            2'd1:    sq_op = mag_reg[1][PRE_W-1:0];
            2'd2:    sq_op = mag_reg[2][PRE_W-1:0];
            default: sq_op = '0;
        endcase
    end

    assign root_trial = root_res_reg + RES_W'(root_bit_reg);
    assign root_ge    = (RES_W'(root_n_reg) >= root_trial);
    assign root_r     = root_res_reg[ROOT_W-1:0];

    // divider operands for the current component
    assign m24   = mag_reg[comp_reg][PRE_W-1:0];
    assign a_val = neg_reg[comp_reg] ? DIV_D_W'({1'b0, root_r} - DIV_D_W'(m24))
                                     : DIV_D_W'({1'b0, root_r} + DIV_D_W'(m24));

    always_comb begin
        if (comp_reg == 2'd2) begin
            num = (NUM_W'(m24) << 9) - (NUM_W'(m24) << 1) + NUM_W'(root_r);
        end else begin
            num = (NUM_W'(a_val) << 8) - NUM_W'(a_val) + NUM_W'(root_r);
        end
        div_req.start   = (state_reg == ST_DIV_GO);
        div_req.divisor = {root_r, 1'b0};
        if (final_reg) begin
            div_req.hi    = num[NUM_W-1:CHAN_W];
            div_req.lo    = {num[CHAN_W-1:0], (QUO_W - CHAN_W)'(0)};
            div_req.iters = ITER_W'(CHAN_W);
        end else begin
            div_req.hi    = DIV_D_W'(m24);
            div_req.lo    = QUO_W'(root_r);
            div_req.iters = ITER_W'(QUO_W);
        end
    end

    dtn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign q_ext    = SUM_W'(div_quo);
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        job_reg   <= job;
                        tri_reg   <= '0;
                        final_reg <= 1'b0;
                        for (int k = 0; k < 3; k++) begin
                            sum_reg[k]  <= '0;
                            chan_reg[k] <= '1;
                        end
                        state_reg <= job.masked ? ST_OUT : ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (!final_reg) begin
                        mag_reg[0] <= xmag;
                        mag_reg[1] <= ymag;
                        mag_reg[2] <= zmag;
                        neg_reg    <= {1'b0, dy[DIFF_W+1], dx[DIFF_W+1]};
                    end else begin
                        for (int k = 0; k < 3; k++) begin
                            mag_reg[k] <= sum_mag[k];
                            neg_reg[k] <= sum_reg[k][SUM_W-1];
                        end
                    end
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    // shift all three together until each fits the squarer
                    if (over) begin
                        for (int k = 0; k < 3; k++) begin
                            mag_reg[k] <= mag_reg[k] >> 1;
                        end
                    end else begin
                        sq_cnt_reg <= '0;
                        prod_reg   <= '0;
                        acc_reg    <= '0;
                        state_reg  <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    prod_reg   <= sq_op * sq_op;
                    acc_reg    <= acc_reg + SQ_W'(prod_reg);
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 2'd3) begin
                        root_n_reg   <= acc_reg + SQ_W'(prod_reg);
                        root_res_reg <= '0;
                        root_bit_reg <= ROOT_BIT0;
                        state_reg    <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (root_bit_reg != '0) begin
                        if (root_ge) begin
                            root_n_reg   <= SQ_W'(RES_W'(root_n_reg) - root_trial);
                            root_res_reg <= (root_res_reg >> 1) + RES_W'(root_bit_reg);
                        end else begin
                            root_res_reg <= root_res_reg >> 1;
                        end
                        root_bit_reg <= root_bit_reg >> 2;
                    end else begin
                        comp_reg <= '0;
                        if (final_reg && (root_r == '0)) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_DIV_GO;
                        end
                    end
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        if (!final_reg) begin
                            sum_reg[comp_reg] <= neg_reg[comp_reg]
                                ? sum_reg[comp_reg] - $signed(q_ext)
                                : sum_reg[comp_reg] + $signed(q_ext);
                        end else begin
                            chan_reg[comp_reg] <= ((comp_reg == 2'd2) && neg_reg[2])
                                ? '0 : div_quo[CHAN_W-1:0];
                        end
                        if (comp_reg == 2'd2) begin
                            comp_reg <= '0;
                            if (final_reg) begin
                                state_reg <= ST_OUT;
                            end else begin
                                if (tri_reg == RING_IW'(RING_N - 1)) begin
                                    final_reg <= 1'b1;
                                end
                                tri_reg   <= tri_nxt;
                                state_reg <= ST_LOAD;
                            end
                        end else begin
                            comp_reg  <= comp_reg + 1'b1;
                            state_reg <= ST_DIV_GO;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_x_reg     <= chan_reg[0];
                        m_y_reg     <= chan_reg[1];
                        m_z_reg     <= chan_reg[2];
                        m_last_reg  <= job_reg.last;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_chan_x        = m_x_reg;
    assign m_chan_y        = m_y_reg;
    assign m_chan_z        = m_z_reg;
    assign m_last_of_frame = m_last_reg;

endmodule

// ----- design/depth_to_normal_map.sv -----
// ----------------------------------------------------------------------------
// Depth to normal map
// Streams signed Q16.8 depth samples in raster order and returns one RGB
// normal (three 8-bit channels) per interior pixel.
// ----------------------------------------------------------------------------
// Border pixels pass through the front end at one beat per clock, unless an
// interior beat ahead waits on a full queue, and give no result. Each interior
// pixel is queued as a job (two-entry queue) and worked by the back end
// between pop and output load: each of the eight triangles takes a load,
// prescale, square-sum, square root and three 31-bit divisions on a shared
// bit-serial divider, and a final renormalize of the sum repeats the steps
// with up to three 8-bit divisions. A pixel with non-positive depth goes
// straight from the pop to the output load. The front end keeps accepting
// beats until the queue is full, and a finished result waits in the output
// register while the next job is worked. The line buffers are two RAMs of
// MAX_WIDTH samples with no clearing pass; the first two rows of a frame only
// fill them. Configuration is written by index (0 width, 1 height, 2 step
// scale); the user must write it only while the block is idle, unenforced.
// ----------------------------------------------------------------------------
`include "depth_to_normal_map_macros.svh"

module depth_to_normal_map import dtn_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DEPTH_BITS-1:0] s_depth_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAN_W-1:0]     m_chan_x,
    output logic [CHAN_W-1:0]     m_chan_y,
    output logic [CHAN_W-1:0]     m_chan_z,
    output logic                  m_last_of_frame
);

    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic [SCALE_W-1:0]  step_scale_reg;

    logic      q_push;
    logic      q_pop;
    job_t      front_job;
    job_t      back_job;
    q_status_t q_stat;

    // Register file: hold the values, drop writes to unused indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            step_scale_reg   <= RST_STEP_SCALE;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[HEIGHT_W-1:0];
                CFG_STEP_SCALE:   step_scale_reg   <= cfg_wdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: advance the raster, shift the window, classify each beat.
    dtn_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_depth_sample (s_depth_sample),
        .image_width    (image_width_reg),
        .image_height   (image_height_reg),
        .q_full         (q_stat.full),
        .push           (q_push),
        .job            (front_job)
    );

    // Queue: decouple the per-beat front end from the long back-end job.
    dtn_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_job  (front_job),
        .pop     (q_pop),
        .rd_job  (back_job),
        .status  (q_stat)
    );

    // Back end: work out the normal and hold it in the output register.
    dtn_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job             (back_job),
        .q_empty         (q_stat.empty),
        .q_pop           (q_pop),
        .step_scale      (step_scale_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chan_x        (m_chan_x),
        .m_chan_y        (m_chan_y),
        .m_chan_z        (m_chan_z),
        .m_last_of_frame (m_last_of_frame)
    );

    // The front end must stall rather than overrun the queue.
    `DTN_ASSERT_IMP(a_push_room, aclk, aresetn, q_push, !q_stat.full, "job pushed into full queue")
    // The back end takes a job only when one is waiting.
    `DTN_ASSERT_IMP(a_pop_data, aclk, aresetn, q_pop, !q_stat.empty, "job popped from empty queue")
    // An empty queue with no push stays empty.
    `DTN_ASSERT_NXT(a_empty_hold, aclk, aresetn, q_stat.empty && !q_push, q_stat.empty, "queue filled without push")

endmodule

// ----- tb/depth_to_normal_map_tb.sv -----
// ----------------------------------------------------------------------------
// Depth to normal map testbench
// Streams depth frames into the block under several register settings and
// idle patterns. An in-bench fixed-point model predicts each interior pixel's
// RGB normal, and every output beat is checked against it in order.
// ----------------------------------------------------------------------------
module depth_to_normal_map_tb;
    import dtn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Stretch of cycles without any beat on either channel before giving up.
    // This leaves a wide margin over a full back-end job for stalls.
    localparam int unsigned STALL_LIMIT = 20000;
    // Settling time after the last expected pixel, for border beats in flight.
    localparam int unsigned SETTLE_CYCLES = 50;
    localparam int unsigned RANDOM_BEATS = 1230;

    typedef struct {
        logic [CHAN_W-1:0] x;
        logic [CHAN_W-1:0] y;
        logic [CHAN_W-1:0] z;
        logic              last;
    } pixel_t;

    // ------------------------------------------------------------------------
    // Normal-map scoreboard: runs the fixed-point normal estimate for every
    // accepted interior beat and checks output pixels against the oldest entry.
    // ------------------------------------------------------------------------
    class normal_scoreboard;
        int unsigned  width_reg  = RST_IMAGE_WIDTH;
        int unsigned  height_reg = RST_IMAGE_HEIGHT;
        longint unsigned scale_reg = RST_STEP_SCALE;
        longint       line_mem[2*MAX_WIDTH];
        longint       win[3][3];
        int unsigned  col_cnt;
        int unsigned  row_cnt;
        pixel_t       pixel_q[$];
        int unsigned  errors;
        int unsigned  pixels_seen;
        int unsigned  masked_seen;
        int           ring_r[8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
        int           ring_c[8] = '{-1, 0, 1, 1, 1, 0, -1, -1};

        function new();
            foreach (line_mem[i]) line_mem[i] = 0;
            foreach (win[i, j]) win[i][j] = 0;
            col_cnt = 0;
            row_cnt = 0;
            errors = 0;
            pixels_seen = 0;
            masked_seen = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg  = val[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg = val[HEIGHT_W-1:0];
                CFG_STEP_SCALE:   scale_reg  = val[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return pixel_q.size();
        endfunction

        function bit at_frame_start();
            return col_cnt == 0 && row_cnt == 0;
        endfunction

        function longint unsigned mag(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res, bit_v;
            res = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > n) bit_v >>= 2;
            while (bit_v != 0) begin
                if (n >= res + bit_v) begin
                    n -= res + bit_v;
                    res = (res >> 1) + bit_v;
                end else begin
                    res >>= 1;
                end
                bit_v >>= 2;
            end
            return res;
        endfunction

        // Shift all three magnitudes down together until each fits 24 bits.
        function longint unsigned shrink_root(inout longint unsigned m0, m1, m2);
            longint unsigned lim;
            lim = 64'd1 << PRE_W;
            while (m0 >= lim || m1 >= lim || m2 >= lim) begin
                m0 >>= 1;
                m1 >>= 1;
                m2 >>= 1;
            end
            return int_sqrt(m0 * m0 + m1 * m1 + m2 * m2);
        endfunction

        function pixel_t shade_pixel();
            pixel_t p;
            longint hc, e1, e2, vx, vy;
            longint sum[3];
            longint unsigned s, m0, m1, m2, r, a, b;
            int n2;
            p.x = 8'hFF;
            p.y = 8'hFF;
            p.z = 8'hFF;
            p.last = 1'b0;
            hc = win[1][1];
            s = (scale_reg == 0) ? 1 : scale_reg;
            if (hc <= 0) begin
                masked_seen++;
                return p;
            end
            sum[0] = 0;
            sum[1] = 0;
            sum[2] = 0;
            for (int t = 0; t < 8; t++) begin
                n2 = (t + 1) % 8;
                e1 = win[1 + ring_r[t]][1 + ring_c[t]] - hc;
                e2 = win[1 + ring_r[n2]][1 + ring_c[n2]] - hc;
                vx = 256 * (ring_c[n2] * e1 - ring_c[t] * e2);
                vy = 256 * (ring_r[t] * e2 - ring_r[n2] * e1);
                m0 = mag(vx);
                m1 = mag(vy);
                m2 = s;
                r = shrink_root(m0, m1, m2);
                // unit vector in Q1.30, rounded half away from zero
                if (r != 0) begin
                    a = ((m0 << 31) + r) / (2 * r);
                    sum[0] += (vx < 0) ? -longint'(a) : longint'(a);
                    a = ((m1 << 31) + r) / (2 * r);
                    sum[1] += (vy < 0) ? -longint'(a) : longint'(a);
                    sum[2] += longint'(((m2 << 31) + r) / (2 * r));
                end
            end
            m0 = mag(sum[0]);
            m1 = mag(sum[1]);
            m2 = mag(sum[2]);
            r = shrink_root(m0, m1, m2);
            if (r == 0) return p;
            a = (sum[0] < 0) ? r - m0 : r + m0;
            b = (sum[1] < 0) ? r - m1 : r + m1;
            p.x = 8'((a * 255 + r) / (2 * r));
            p.y = 8'((b * 255 + r) / (2 * r));
            p.z = (sum[2] < 0) ? 8'd0 : 8'((510 * m2 + r) / (2 * r));
            return p;
        endfunction

        function void note_depth(logic [DEPTH_BITS-1:0] raw);
            int unsigned w, h, col;
            longint cur, top, mid;
            pixel_t p;
            w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
            if (w < MIN_DIM) w = MIN_DIM;
            h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
            col = col_cnt % MAX_WIDTH;
            cur = longint'($signed(raw));
            top = line_mem[MAX_WIDTH + col];
            mid = line_mem[col];
            line_mem[MAX_WIDTH + col] = mid;
            line_mem[col] = cur;
            for (int k = 0; k < 3; k++) begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = cur;
            if (row_cnt >= 2 && col >= 2) begin
                p = shade_pixel();
                p.last = (row_cnt == h - 1 && col == w - 1);
                pixel_q = {pixel_q, p};
            end
            if (col + 1 >= w) begin
                col_cnt = 0;
                row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
            end else begin
                col_cnt = col + 1;
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pixel_q.size() == 0) begin
                $error("pixel beat with no pixel expected");
                errors++;
                return;
            end
            want = pixel_q.pop_front();
            pixels_seen++;
            if (got.x !== want.x) begin
                $error("chan_x: expected %0d, got %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $error("chan_y: expected %0d, got %0d", want.y, got.y);
                errors++;
            end
            if (got.z !== want.z) begin
                $error("chan_z: expected %0d, got %0d", want.z, got.z);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_of_frame: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [DEPTH_BITS-1:0] s_depth_sample = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CHAN_W-1:0]     m_chan_x;
    logic [CHAN_W-1:0]     m_chan_y;
    logic [CHAN_W-1:0]     m_chan_z;
    logic                  m_last_of_frame;

    normal_scoreboard sb = new();
    int unsigned beats_in = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned phases_run = 0;

    depth_to_normal_map dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_depth_sample  (s_depth_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chan_x        (m_chan_x),
        .m_chan_y        (m_chan_y),
        .m_chan_z        (m_chan_z),
        .m_last_of_frame (m_last_of_frame)
    );

    always #5 aclk = ~aclk;

    // Receiver: stall at random according to the current idle pattern.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Sample both channels on the rising edge; feed the scoreboard and the
    // watchdog. Any beat on either side resets the quiet count.
    always @(posedge aclk) begin
        pixel_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_depth(s_depth_sample);
                beats_in++;
            end
            if (m_valid && m_ready) begin
                got.x = m_chan_x;
                got.y = m_chan_y;
                got.z = m_chan_z;
                got.last = m_last_of_frame;
                sb.check_pixel(got);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Present one depth beat, hold it until taken, then maybe idle a while.
    task automatic send_depth(input logic [DEPTH_BITS-1:0] d);
        int unsigned seen;
        seen = beats_in;
        s_depth_sample <= d;
        s_valid <= 1'b1;
        do @(negedge aclk); while (beats_in == seen);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    // Drop valid, wait until every expected pixel is out, then let border
    // beats settle.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write all three registers back to back; call only while idle.
    task automatic apply_cfg(input int unsigned w, input int unsigned h,
                             input int unsigned s);
        logic [CFG_ADDR_W-1:0] idx[3];
        int unsigned val[3];
        idx = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_STEP_SCALE};
        val = '{w, h, s};
        for (int i = 0; i < 3; i++) begin
            cfg_we <= 1'b1;
            cfg_addr <= idx[i];
            cfg_wdata <= val[i][CFG_DATA_W-1:0];
            sb.set_reg(idx[i], val[i][CFG_DATA_W-1:0]);
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // Depth around a surface level with small slopes, plus masked samples,
    // extremes and full-range noise so every input bit toggles.
    function automatic logic [DEPTH_BITS-1:0] pick_depth(input int base,
                                                         input int unsigned mask_pct);
        if ($urandom_range(0, 99) < mask_pct)
            return DEPTH_BITS'(-$signed($urandom_range(0, 8388608)));
        case ($urandom_range(0, 9))
            0:       return DEPTH_BITS'($urandom);
            1:       return 24'h7FFFFF;
            2:       return DEPTH_BITS'($urandom_range(1, 8388607));
            default: return DEPTH_BITS'(base + $signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    // Rotate through the idle patterns, one per phase.
    task automatic next_idle_pattern();
        case (phases_run % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
        phases_run++;
    endtask

    // Feed beats until the model sits at the start of a frame.
    task automatic finish_frame(input int base, input int unsigned mask_pct);
        while (!sb.at_frame_start()) send_depth(pick_depth(base, mask_pct));
    endtask

    initial begin
        int unsigned rand_beats;
        int unsigned w, h, s, frames, base;
        logic [DEPTH_BITS-1:0] hot[9];

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset values rewritten, then clamped registers (width and
        // height below three, scale zero) on 3x3 and 4x3 frames with extremes.
        apply_cfg(RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT, RST_STEP_SCALE);
        apply_cfg(2, 0, 0);
        // deepest centre against shallowest ring: widest prescale
        hot = '{24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF,
                24'h800000, 24'h800000, 24'h800000, 24'h800000};
        foreach (hot[i]) send_depth(hot[i]);
        drain();
        apply_cfg(1, 2, 24'hFFFFFF);
        // minimal positive centre, ring alternating high and zero
        hot = '{24'h7FFFFF, 24'h000000, 24'h7FFFFF, 24'h000000, 24'h000001,
                24'h000000, 24'h7FFFFF, 24'h000000, 24'h7FFFFF};
        foreach (hot[i]) send_depth(hot[i]);
        drain();
        apply_cfg(3, 3, 1);
        // masked centres: zero, then most negative
        hot = '{24'h000100, 24'h000200, 24'h000300, 24'h000400, 24'h000000,
                24'h000500, 24'h000600, 24'h000700, 24'h000800};
        foreach (hot[i]) send_depth(hot[i]);
        drain();
        apply_cfg(4, 3, 65536);
        for (int i = 0; i < 12; i++)
            send_depth((i == 5) ? 24'h800000 : DEPTH_BITS'(2560 + 64 * i));

        // Width above the clamp: part of a 1,024-sample row, then width
        // lowered mid-row so the column count wraps early.
        drain();
        next_idle_pattern();
        apply_cfg(2047, 3, 32768);
        base = 60000;
        for (int i = 0; i < 100; i++) send_depth(pick_depth(base, 90));
        drain();
        apply_cfg(5, 3, 32768);
        finish_frame(base, 90);

        // Tallest frame: start it, then lower height mid-frame so the row
        // count wraps early, with a new step scale taking effect at once.
        drain();
        next_idle_pattern();
        apply_cfg(3, 4095, 16777215);
        for (int i = 0; i < 21; i++) send_depth(pick_depth(20000, 20));
        drain();
        apply_cfg(3, 4, $urandom_range(1, 16777215));
        finish_frame(20000, 20);

        // Random phases: small frames with random settings, whole frames each.
        rand_beats = 0;
        while (rand_beats < RANDOM_BEATS) begin
            drain();
            next_idle_pattern();
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 2);
                1:       w = $urandom_range(9, 16);
                default: w = $urandom_range(3, 8);
            endcase
            h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            case ($urandom_range(0, 5))
                0:       s = 0;
                1:       s = 1;
                2:       s = 16777215;
                3:       s = $urandom_range(0, 16777215);
                default: s = $urandom_range(2048, 262144);
            endcase
            apply_cfg(w, h, s);
            base = $urandom_range(256, 2000000);
            frames = $urandom_range(1, 2);
            for (int f = 0; f < frames; f++) begin
                do begin
                    send_depth(pick_depth(base, 25));
                    rand_beats++;
                end while (!sb.at_frame_start());
            end
        end

        drain();

        $display("Run covered %0d depth beats over %0d phases: %0d pixels checked,",
                 beats_in, phases_run, sb.pixels_seen);
        $display("%0d of them masked, widths 3 to 1024 and heights 3 to 4095.",
                 sb.masked_seen);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
